FILE: rtl/sfrc_pkg.sv
// ----------------------------------------------------------------------------
// sfrc_pkg - shared types and constants for the sync frame receiver
// Parse phases, status codes, check modes, controller commands and the
// check accumulator step.
// ----------------------------------------------------------------------------
package sfrc_pkg;

    localparam int FRAME_MAX_DEF = 64;

    localparam logic [7:0]  SYNC1_BYTE = 8'h55;
    localparam logic [7:0]  SYNC2_BYTE = 8'hAA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] MIN_LEN    = 16'd7;    // sync, length, type, check

    localparam int TDATA_W = 32;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_XOR  = 2'd1;
    localparam logic [1:0] MODE_CRC  = 2'd2;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_TYPE  = 3'd4,
        PH_DATA  = 3'd5,
        PH_CHKHI = 3'd6,
        PH_CHKLO = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_HUNT    = 3'd0,
        ST_INSIDE  = 3'd1,
        ST_GOOD    = 3'd2,
        ST_CHK_ERR = 3'd3,
        ST_LEN_ERR = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_EXEC = 2'd1,
        CS_READ = 2'd2,
        CS_PUT  = 2'd3
    } t_ctl_state;

    typedef struct packed {
        logic load;      // capture received byte
        logic step;      // run parser on held byte, load status beat
        logic rd_issue;  // read payload buffer at read pointer
        logic put;       // load payload beat, advance read pointer
    } t_ctl_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a beat this cycle
        logic burst;     // current step accepts a frame with payload
        logic pay_last;  // read pointer is on the final payload byte
    } t_dp_sts;

    // fold one byte into the running check
    function automatic logic [15:0] fold_byte(input logic [1:0]  mode,
                                              input logic [15:0] chk,
                                              input logic [7:0]  b);
        logic [7:0]  x;
        logic [15:0] x16;
        logic [15:0] res;
        x   = chk[15:8] ^ b;
        x   = x ^ (x >> 4);
        x16 = {8'h00, x};
        unique case (mode)
            MODE_XOR: res = chk ^ {8'h00, b};
            MODE_CRC: res = (chk << 8) ^ (x16 << 12) ^ (x16 << 5) ^ x16;
            default:  res = chk;
        endcase
        return res;
    endfunction

    function automatic logic [15:0] expected_check(input logic [1:0]  mode,
                                                   input logic [15:0] chk);
        logic [15:0] res;
        unique case (mode)
            MODE_XOR: res = {8'h00, chk[7:0]};
            MODE_CRC: res = chk;
            default:  res = 16'h0000;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/sfrc_ctrl.sv
// ----------------------------------------------------------------------------
// sfrc_ctrl - sequencing controller
// Takes one byte, runs one parser step, then drains the payload buffer
// one beat per read/put pair when a frame is accepted.
// ----------------------------------------------------------------------------
module sfrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output sfrc_pkg::t_ctl_cmd o_cmd,
    input  sfrc_pkg::t_dp_sts  i_sts
);

    sfrc_pkg::t_ctl_state r_state;
    sfrc_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfrc_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfrc_pkg::CS_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = sfrc_pkg::CS_EXEC;
                end
            end
            sfrc_pkg::CS_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.burst ? sfrc_pkg::CS_READ : sfrc_pkg::CS_IDLE;
                end
            end
            sfrc_pkg::CS_READ: begin
                n_state = sfrc_pkg::CS_PUT;
            end
            sfrc_pkg::CS_PUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.pay_last ? sfrc_pkg::CS_IDLE : sfrc_pkg::CS_READ;
                end
            end
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.put      = 1'b0;
        unique case (r_state)
            sfrc_pkg::CS_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            sfrc_pkg::CS_EXEC: begin
                o_cmd.step = i_sts.out_free;
            end
            sfrc_pkg::CS_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            sfrc_pkg::CS_PUT: begin
                o_cmd.put = i_sts.out_free;
            end
        endcase
    end

endmodule

FILE: rtl/sfrc_dpath.sv
// ----------------------------------------------------------------------------
// sfrc_dpath - parser datapath
// Frame parse state, check accumulator, payload buffer and output register.
// ----------------------------------------------------------------------------
module sfrc_dpath #(
    parameter int FRAME_MAX = sfrc_pkg::FRAME_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_data,
    input  logic [7:0]                   i_rx_byte,
    input  sfrc_pkg::t_ctl_cmd           i_cmd,
    output sfrc_pkg::t_dp_sts            o_sts,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [sfrc_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                         o_m_tuser,
    output logic                         o_m_tlast
);

    localparam int PAY_MAX = FRAME_MAX - 7;
    localparam int IDX_W   = $clog2(PAY_MAX + 1);
    localparam int ADDR_W  = (PAY_MAX > 1) ? $clog2(PAY_MAX) : 1;

    // configuration and parse state
    logic [1:0]       r_mode;
    sfrc_pkg::t_phase r_phase;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_len;
    logic [7:0]       r_type;
    logic [15:0]      r_check;
    logic [7:0]       r_byte;
    logic [IDX_W-1:0] r_pay_n;

    sfrc_pkg::t_phase n_phase;
    logic [IDX_W-1:0] n_idx;
    logic [15:0]      n_len;
    logic [7:0]       n_type;
    logic [15:0]      n_check;

    // payload buffer and read side
    logic [7:0]        r_mem [PAY_MAX];
    logic [ADDR_W-1:0] r_rd_idx;
    logic [7:0]        r_rd_data;

    // output register
    logic                         r_out_valid;
    logic [sfrc_pkg::TDATA_W-1:0] r_out_data;
    logic                         r_out_user;
    logic                         r_out_last;

    sfrc_pkg::t_status w_status;
    logic              w_good;
    logic              w_wr_en;
    logic [15:0]       w_exp;
    logic [15:0]       w_len_lo;
    logic [15:0]       w_pay_len;
    logic [IDX_W-1:0]  w_new_n;
    logic [15:0]       w_n16;
    logic [15:0]       w_cur_n16;
    logic              w_rd_last;

    assign w_exp     = sfrc_pkg::expected_check(r_mode, r_check);
    assign w_len_lo  = {r_len[15:8], r_byte};
    assign w_pay_len = r_len - sfrc_pkg::MIN_LEN;
    assign w_new_n   = w_pay_len[IDX_W-1:0];

    // one parser step on the held byte
    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_len    = r_len;
        n_type   = r_type;
        n_check  = r_check;
        w_status = sfrc_pkg::ST_INSIDE;
        w_good   = 1'b0;
        w_wr_en  = 1'b0;
        unique case (r_phase)
            sfrc_pkg::PH_SYNC1: begin
                if (r_byte == sfrc_pkg::SYNC1_BYTE) begin
                    n_check = sfrc_pkg::fold_byte(r_mode,
                        (r_mode == sfrc_pkg::MODE_CRC) ? sfrc_pkg::CRC_INIT : 16'h0000,
                        r_byte);
                    n_idx   = '0;
                    n_phase = sfrc_pkg::PH_SYNC2;
                end else begin
                    w_status = sfrc_pkg::ST_HUNT;
                end
            end
            sfrc_pkg::PH_SYNC2: begin
                if (r_byte == sfrc_pkg::SYNC2_BYTE) begin
                    n_check = sfrc_pkg::fold_byte(r_mode, r_check, r_byte);
                    n_phase = sfrc_pkg::PH_LENHI;
                end else begin
                    n_phase  = sfrc_pkg::PH_SYNC1;
                    w_status = sfrc_pkg::ST_HUNT;
                end
            end
            sfrc_pkg::PH_LENHI: begin
                n_check = sfrc_pkg::fold_byte(r_mode, r_check, r_byte);
                n_len   = {r_byte, 8'h00};
                n_phase = sfrc_pkg::PH_LENLO;
            end
            sfrc_pkg::PH_LENLO: begin
                n_check = sfrc_pkg::fold_byte(r_mode, r_check, r_byte);
                n_len   = w_len_lo;
                if (w_len_lo < sfrc_pkg::MIN_LEN || w_len_lo > 16'(FRAME_MAX)) begin
                    n_phase  = sfrc_pkg::PH_SYNC1;
                    w_status = sfrc_pkg::ST_LEN_ERR;
                end else begin
                    n_phase = sfrc_pkg::PH_TYPE;
                end
            end
            sfrc_pkg::PH_TYPE: begin
                n_check = sfrc_pkg::fold_byte(r_mode, r_check, r_byte);
                n_type  = r_byte;
                n_phase = (r_len == sfrc_pkg::MIN_LEN) ? sfrc_pkg::PH_CHKHI
                                                       : sfrc_pkg::PH_DATA;
            end
            sfrc_pkg::PH_DATA: begin
                n_check = sfrc_pkg::fold_byte(r_mode, r_check, r_byte);
                w_wr_en = (16'(r_idx) < 16'(PAY_MAX));
                n_idx   = r_idx + 1'b1;
                if (16'(r_idx) + 16'd1 >= w_pay_len) begin
                    n_phase = sfrc_pkg::PH_CHKHI;
                end
            end
            sfrc_pkg::PH_CHKHI: begin
                if (r_byte == w_exp[15:8]) begin
                    n_phase = sfrc_pkg::PH_CHKLO;
                end else begin
                    n_phase  = sfrc_pkg::PH_SYNC1;
                    w_status = sfrc_pkg::ST_CHK_ERR;
                end
            end
            sfrc_pkg::PH_CHKLO: begin
                n_phase = sfrc_pkg::PH_SYNC1;
                if (r_byte == w_exp[7:0]) begin
                    w_status = sfrc_pkg::ST_GOOD;
                    w_good   = 1'b1;
                end else begin
                    w_status = sfrc_pkg::ST_CHK_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sfrc_pkg::MODE_ZERO;
            r_phase <= sfrc_pkg::PH_SYNC1;
            r_idx   <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_check <= sfrc_pkg::CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.step) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_len   <= n_len;
                r_type  <= n_type;
                r_check <= n_check;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.step && w_good) begin
            r_pay_n <= w_new_n;
        end
    end

    // payload buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_wr_en) begin
            r_mem[r_idx[ADDR_W-1:0]] <= r_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.step) begin
            r_rd_idx <= '0;
        end else if (i_cmd.put) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    assign w_n16     = 16'(w_new_n);
    assign w_cur_n16 = 16'(r_pay_n);
    assign w_rd_last = (16'(r_rd_idx) + 16'd1 == w_cur_n16);

    // output register: tdata = {pad, data_byte, payload_count, frame_type, status}
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step || i_cmd.put) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_user <= sfrc_pkg::KIND_STATUS;
            r_out_data <= {7'd0, 8'h00, (w_good ? w_n16[5:0] : 6'd0), n_type, w_status};
            r_out_last <= w_good ? (w_new_n == '0) : 1'b1;
        end else if (i_cmd.put) begin
            r_out_user <= sfrc_pkg::KIND_PAYLOAD;
            r_out_data <= {7'd0, r_rd_data, w_cur_n16[5:0], r_type, sfrc_pkg::ST_GOOD};
            r_out_last <= w_rd_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_sts.burst    = w_good && (w_new_n != '0);
    assign o_sts.pay_last = w_rd_last;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: rtl/sync_frame_receiver_checksum.sv
// ----------------------------------------------------------------------------
// sync_frame_receiver_checksum - sync/length/type frame receiver with check
// Hunts for the sync pair, parses length, type, payload and check value,
// and replays the payload of each good frame after its status beat.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  content
//  s_axis    in   s_axis_tvalid/tready       rx_byte
//  m_axis    out  m_axis_tvalid/tready       status/type/count/data, tuser kind,
//                                            tlast last beat of a byte's results
//  cfg       in   i_cfg_we                   check_mode
//
//  Each received byte is captured, then run through one parser step once the output
//  register is free; the status beat is written by the parser step.
//  A good frame then drains n payload beats, each as a read and then a put, set by the
//  registered read of the single-port payload buffer.
//  A stall on m_axis holds the block in the step or drain state.
//  Synchronous active-low reset; the payload buffer needs no clearing.
// ----------------------------------------------------------------------------
module sync_frame_receiver_checksum #(
    parameter int FRAME_MAX = sfrc_pkg::FRAME_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [2:0] status, [10:3] frame_type, [16:11] payload_count, [24:17] data_byte
    output logic [sfrc_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tuser,  // [0] result_kind
    output logic                         m_axis_tlast
);

    sfrc_pkg::t_ctl_cmd w_cmd;
    sfrc_pkg::t_dp_sts  w_sts;

    sfrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    sfrc_dpath #(
        .FRAME_MAX (FRAME_MAX)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rx_byte  (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

FILE: bench/sync_frame_receiver_checksum_tb.sv
// ----------------------------------------------------------------------------
// sync_frame_receiver_checksum_tb - self-checking bench for the frame receiver
// Drives serial bytes into the stream input with random gaps and stalls the
// result stream at random. A parser model built into the bench predicts every
// status and payload beat, and a scoreboard compares them in order. Covers
// sync hunting, length limits, all check modes, check faults and mode changes
// made part-way through a frame.
// ----------------------------------------------------------------------------
module sync_frame_receiver_checksum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAME_MAX  = sfrc_pkg::FRAME_MAX_DEF;
    localparam int          PAY_MAX    = FRAME_MAX - 7;
    localparam int          WDOG_LIMIT = 1000;
    localparam int          IDLE_WAIT  = 8;
    localparam logic [1:0]  MODE_SPARE = 2'd3;
    localparam logic [15:0] CCITT_POLY = 16'h1021;
    localparam int          FAULT_NONE = 0;
    localparam int          FAULT_HI   = 1;
    localparam int          FAULT_LO   = 2;

    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic [7:0] ftype;
        logic [5:0] count;
        logic [7:0] data;
        logic       last;
    } t_rx_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [1:0]                   i_cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata;   // [7:0] rx_byte
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // [2:0] status, [10:3] frame_type, [16:11] payload_count, [24:17] data_byte
    logic [sfrc_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                         m_axis_tuser;   // [0] result_kind
    logic                         m_axis_tlast;

    // parser model state
    logic [1:0]       mode_q;
    sfrc_pkg::t_phase ph_q;
    logic [15:0]      pay_idx_q;
    logic [15:0]      len_q;
    logic [7:0]       type_q;
    logic [15:0]      chk_q;
    logic [7:0]       pay_store [PAY_MAX];

    t_rx_beat beats_due [$];

    int  bytes_sent;
    int  beats_seen;
    int  err_count;
    int  good_frames;
    int  payload_beats;
    int  chk_errors;
    int  len_errors;
    bit  gaps_off;
    int  stall_left;
    int  stall_draw;
    int  quiet_cycles;

    sync_frame_receiver_checksum dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // check update per mode: xor of the byte, or a bitwise CCITT update, MSB first
    function automatic logic [15:0] fold_check(input logic [1:0] m, input logic [15:0] acc,
                                               input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        if (m == sfrc_pkg::MODE_XOR) begin
            r = acc ^ {8'h00, b};
        end else if (m == sfrc_pkg::MODE_CRC) begin
            r = acc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++) begin
                r = r[15] ? ((r << 1) ^ CCITT_POLY) : (r << 1);
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] frame_check_target();
        logic [15:0] r;
        r = 16'h0000;
        if (mode_q == sfrc_pkg::MODE_XOR) r = {8'h00, chk_q[7:0]};
        else if (mode_q == sfrc_pkg::MODE_CRC) r = chk_q;
        return r;
    endfunction

    function automatic t_rx_beat make_beat(input logic kind, input sfrc_pkg::t_status st,
                                           input logic [5:0] cnt, input logic [7:0] d,
                                           input logic lst);
        t_rx_beat r;
        r.kind   = kind;
        r.status = st;
        r.ftype  = type_q;
        r.count  = cnt;
        r.data   = d;
        r.last   = lst;
        return r;
    endfunction

    // advance the parser model by one accepted byte and queue its beats
    task automatic parse_rx_byte(input logic [7:0] b);
        sfrc_pkg::t_status st;
        bit                good;
        logic [15:0]       tgt;
        int                n;
        st   = sfrc_pkg::ST_INSIDE;
        good = 1'b0;
        tgt  = frame_check_target();
        unique case (ph_q)
            sfrc_pkg::PH_SYNC1: begin
                if (b == sfrc_pkg::SYNC1_BYTE) begin
                    chk_q     = fold_check(mode_q,
                        (mode_q == sfrc_pkg::MODE_CRC) ? sfrc_pkg::CRC_INIT : 16'h0000, b);
                    pay_idx_q = 16'd0;
                    ph_q      = sfrc_pkg::PH_SYNC2;
                end else begin
                    st = sfrc_pkg::ST_HUNT;
                end
            end
            sfrc_pkg::PH_SYNC2: begin
                if (b == sfrc_pkg::SYNC2_BYTE) begin
                    chk_q = fold_check(mode_q, chk_q, b);
                    ph_q  = sfrc_pkg::PH_LENHI;
                end else begin
                    ph_q = sfrc_pkg::PH_SYNC1;
                    st   = sfrc_pkg::ST_HUNT;
                end
            end
            sfrc_pkg::PH_LENHI: begin
                chk_q = fold_check(mode_q, chk_q, b);
                len_q = {b, 8'h00};
                ph_q  = sfrc_pkg::PH_LENLO;
            end
            sfrc_pkg::PH_LENLO: begin
                chk_q      = fold_check(mode_q, chk_q, b);
                len_q[7:0] = b;
                if (len_q < sfrc_pkg::MIN_LEN || len_q > FRAME_MAX) begin
                    ph_q = sfrc_pkg::PH_SYNC1;
                    st   = sfrc_pkg::ST_LEN_ERR;
                end else begin
                    ph_q = sfrc_pkg::PH_TYPE;
                end
            end
            sfrc_pkg::PH_TYPE: begin
                chk_q  = fold_check(mode_q, chk_q, b);
                type_q = b;
                ph_q   = (len_q == sfrc_pkg::MIN_LEN) ? sfrc_pkg::PH_CHKHI
                                                      : sfrc_pkg::PH_DATA;
            end
            sfrc_pkg::PH_DATA: begin
                chk_q = fold_check(mode_q, chk_q, b);
                if (pay_idx_q < PAY_MAX) pay_store[pay_idx_q] = b;
                pay_idx_q++;
                if (pay_idx_q >= len_q - sfrc_pkg::MIN_LEN) ph_q = sfrc_pkg::PH_CHKHI;
            end
            sfrc_pkg::PH_CHKHI: begin
                if (b == tgt[15:8]) begin
                    ph_q = sfrc_pkg::PH_CHKLO;
                end else begin
                    ph_q = sfrc_pkg::PH_SYNC1;
                    st   = sfrc_pkg::ST_CHK_ERR;
                end
            end
            default: begin
                ph_q = sfrc_pkg::PH_SYNC1;
                if (b == tgt[7:0]) good = 1'b1;
                else st = sfrc_pkg::ST_CHK_ERR;
            end
        endcase
        if (good) begin
            n = int'(len_q - sfrc_pkg::MIN_LEN);
            if (n > PAY_MAX) n = PAY_MAX;
            beats_due.push_back(make_beat(sfrc_pkg::KIND_STATUS, sfrc_pkg::ST_GOOD, 6'(n),
                                          8'h00, n == 0));
            for (int i = 0; i < n; i++) begin
                beats_due.push_back(make_beat(sfrc_pkg::KIND_PAYLOAD, sfrc_pkg::ST_GOOD,
                                              6'(n), pay_store[i], i + 1 == n));
            end
        end else begin
            beats_due.push_back(make_beat(sfrc_pkg::KIND_STATUS, st, 6'd0, 8'h00, 1'b1));
        end
    endtask

    // one beat on the input stream; valid stays up across back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_off ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        parse_rx_byte(b);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_q = m;
    endtask

    task automatic send_header(input logic [15:0] len, input logic [7:0] ftype);
        send_byte(sfrc_pkg::SYNC1_BYTE);
        send_byte(sfrc_pkg::SYNC2_BYTE);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(ftype);
    endtask

    // fault: clean, bad high check byte or bad low check byte
    task automatic send_frame(input int npay, input int fault);
        logic [15:0] tgt;
        logic [7:0]  hi;
        logic [7:0]  lo;
        send_header(16'(npay) + sfrc_pkg::MIN_LEN, 8'($urandom));
        for (int i = 0; i < npay; i++) send_byte(8'($urandom));
        tgt = frame_check_target();
        hi  = tgt[15:8];
        lo  = tgt[7:0];
        if (fault == FAULT_HI) hi ^= 8'($urandom_range(1, 255));
        if (fault == FAULT_LO) lo ^= 8'($urandom_range(1, 255));
        send_byte(hi);
        send_byte(lo);
    endtask

    function automatic int draw_payload_len();
        return ($urandom_range(0, 11) == 0) ? $urandom_range(9, PAY_MAX)
                                            : $urandom_range(0, 8);
    endfunction

    task automatic test_hunting();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sfrc_pkg::SYNC2_BYTE);
        send_byte(sfrc_pkg::SYNC1_BYTE);
        send_byte(sfrc_pkg::SYNC1_BYTE);   // wrong second sync, not a new first sync
        send_byte(sfrc_pkg::SYNC2_BYTE);
    endtask

    task automatic test_length_limits();
        send_byte(sfrc_pkg::SYNC1_BYTE);
        send_byte(sfrc_pkg::SYNC2_BYTE);
        send_byte(8'h00);
        send_byte(8'h06);
        send_byte(sfrc_pkg::SYNC1_BYTE);
        send_byte(sfrc_pkg::SYNC2_BYTE);
        send_byte(8'h00);
        send_byte(8'(FRAME_MAX + 1));
        send_byte(sfrc_pkg::SYNC1_BYTE);
        send_byte(sfrc_pkg::SYNC2_BYTE);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    task automatic test_min_frame();
        send_header(sfrc_pkg::MIN_LEN, 8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
    endtask

    task automatic test_max_frame();
        set_mode(sfrc_pkg::MODE_CRC);
        send_frame(PAY_MAX, FAULT_NONE);
    endtask

    task automatic test_mode_switch_mid_frame();
        logic [15:0] tgt;
        set_mode(sfrc_pkg::MODE_XOR);
        send_header(sfrc_pkg::MIN_LEN + 16'd4, 8'($urandom));
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        set_mode(sfrc_pkg::MODE_CRC);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        tgt = frame_check_target();
        send_byte(tgt[15:8]);
        send_byte(tgt[7:0]);
        // zero mode leaves the accumulator at 0, then xor folds the payload only
        set_mode(sfrc_pkg::MODE_ZERO);
        send_header(sfrc_pkg::MIN_LEN + 16'd2, 8'($urandom));
        set_mode(sfrc_pkg::MODE_XOR);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        tgt = frame_check_target();
        send_byte(tgt[15:8]);
        send_byte(tgt[7:0]);
    endtask

    task automatic test_random_frames(input logic [1:0] m, input int budget);
        int          start;
        int          sel;
        int          npay;
        logic [15:0] len;
        logic [7:0]  b;
        set_mode(m);
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            gaps_off = ($urandom_range(0, 3) == 0);
            sel      = $urandom_range(0, 99);
            if (sel < 65) begin
                send_frame(draw_payload_len(), FAULT_NONE);
            end else if (sel < 75) begin
                send_frame($urandom_range(0, 6), $urandom_range(FAULT_HI, FAULT_LO));
            end else if (sel < 83) begin
                len = $urandom_range(0, 1) ? 16'($urandom_range(0, 6))
                                           : 16'($urandom_range(FRAME_MAX + 1, 65535));
                send_byte(sfrc_pkg::SYNC1_BYTE);
                send_byte(sfrc_pkg::SYNC2_BYTE);
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end else if (sel < 91) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (sel < 96) begin
                b = 8'($urandom);
                if (b == sfrc_pkg::SYNC2_BYTE) b = ~b;
                send_byte(sfrc_pkg::SYNC1_BYTE);
                send_byte(b);
            end else begin
                // truncated frame: what follows is swallowed as payload
                npay = $urandom_range(2, 8);
                send_header(16'(npay) + sfrc_pkg::MIN_LEN, 8'($urandom));
                repeat ($urandom_range(0, npay - 1)) send_byte(8'($urandom));
            end
        end
        gaps_off = 1'b0;
    endtask

    // result side: random stalls and in-order scoreboard
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin : score
            t_rx_beat got;
            t_rx_beat want;
            got.kind   = m_axis_tuser;
            got.status = m_axis_tdata[2:0];
            got.ftype  = m_axis_tdata[10:3];
            got.count  = m_axis_tdata[16:11];
            got.data   = m_axis_tdata[24:17];
            got.last   = m_axis_tlast;
            beats_seen++;
            if (beats_due.size() == 0) begin
                if (err_count < 10)
                    $display({"unexpected beat: kind %0d status %0d type %02h count %0d",
                              " data %02h last %0d"},
                             got.kind, got.status, got.ftype, got.count, got.data,
                             got.last);
                err_count++;
            end else begin
                want = beats_due.pop_front();
                if (want.kind == sfrc_pkg::KIND_PAYLOAD) payload_beats++;
                else if (want.status == sfrc_pkg::ST_GOOD) good_frames++;
                else if (want.status == sfrc_pkg::ST_CHK_ERR) chk_errors++;
                else if (want.status == sfrc_pkg::ST_LEN_ERR) len_errors++;
                if (got !== want || m_axis_tdata[sfrc_pkg::TDATA_W-1:25] !== '0) begin
                    if (err_count < 10) begin
                        $display({"beat %0d mismatch: exp kind %0d st %0d type %02h",
                                  " cnt %0d data %02h last %0d"},
                                 beats_seen, want.kind, want.status, want.ftype,
                                 want.count, want.data, want.last);
                        $display({"    got kind %0d st %0d type %02h cnt %0d data %02h",
                                  " last %0d tdata %08h"},
                                 got.kind, got.status, got.ftype, got.count, got.data,
                                 got.last, m_axis_tdata);
                    end
                    err_count++;
                end
            end
            stall_draw = gaps_off ? 0 : $urandom_range(0, 16);
            if (stall_draw == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_draw;
            end
        end else if (!m_axis_tready) begin
            if (stall_left <= 1) m_axis_tready <= 1'b1;
            else stall_left <= stall_left - 1;
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d beats still due",
                     WDOG_LIMIT, beats_due.size());
            $display("sync_frame_receiver_checksum_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= sfrc_pkg::MODE_ZERO;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        quiet_cycles  =  0;
        mode_q        = sfrc_pkg::MODE_ZERO;
        ph_q          = sfrc_pkg::PH_SYNC1;
        pay_idx_q     = 16'd0;
        len_q         = 16'd0;
        type_q        = 8'h00;
        chk_q         = sfrc_pkg::CRC_INIT;
        bytes_sent    = 0;
        beats_seen    = 0;
        err_count     = 0;
        good_frames   = 0;
        payload_beats = 0;
        chk_errors    = 0;
        len_errors    = 0;
        gaps_off      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hunting();
        test_length_limits();
        test_min_frame();
        test_max_frame();
        test_random_frames(sfrc_pkg::MODE_XOR, 40);
        test_random_frames(sfrc_pkg::MODE_CRC, 45);
        test_random_frames(MODE_SPARE, 20);
        test_mode_switch_mid_frame();
        test_random_frames(sfrc_pkg::MODE_ZERO, 35);
        wait_idle();

        if (beats_due.size() != 0) err_count += beats_due.size();
        $display("run covered %0d bytes in check modes zero, xor, crc and spare, %0d beats checked",
                 bytes_sent, beats_seen);
        $display({"%0d good frames, %0d payload beats, %0d check errors,",
                  " %0d length errors, %0d failures"},
                 good_frames, payload_beats, chk_errors, len_errors, err_count);
        if (err_count == 0) begin
            $display("sync_frame_receiver_checksum_tb OK");
        end else begin
            $display("sync_frame_receiver_checksum_tb NOT OK");
        end
        $finish;
    end

endmodule
